FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Holds the queue depth, opcode and status codes, and the per-cell
// control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // Number of storage cells in the chain.
    localparam int QUEUE_DEPTH = 8;
    // Width of the fill counter; it must be able to hold QUEUE_DEPTH itself.
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Opcodes carried on the input tuser.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Status codes carried on the output tuser.
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef logic signed [31:0] entry_t;
    typedef logic [CNT_W-1:0] count_t;

    // Control bundle handed to every cell in the chain.
    typedef struct packed {
        logic insert;    // shift toward the tail and place the new value
        logic remove;    // shift toward the head
        logic occupied;  // this cell holds a valid entry
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one storage cell of the sorted chain
// Holds one entry, decides whether it keeps its value on an insert, and
// otherwise takes the new value or its neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire        aclk,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_value,
    input  wire        left_keep,   // neighbor toward the head keeps its entry
    input  entry_t     left_entry,  // entry of the neighbor toward the head
    input  entry_t     right_entry, // entry of the neighbor toward the tail
    output logic       keep,
    output entry_t     entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // A valid entry that is not smaller than the new value stays put, so
    // equal values keep their arrival order.
    assign keep  = ctrl.occupied && !(entry_reg < new_value);
    assign entry = entry_reg;

    // Next entry: hold, take the new value at the insertion point, or shift.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.insert) begin
            if (keep) begin
                entry_next = entry_reg;
            end else if (left_keep) begin
                entry_next = new_value;
            end else begin
                entry_next = left_entry;
            end
        end else if (ctrl.remove) begin
            entry_next = right_entry;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

FILE: rtl/sorted_priority_queue.sv
// A result word is registered and appears on the master side in the cycle after
// its input word is accepted.
// Throughput: one insert or remove per cycle; the cell chain updates all
// entries in parallel, and a new word enters in the same cycle that the waiting
// result is taken, so a stalled master side stalls the input. Reset clears the
// fill count and the output valid; entries are not cleared, since only cells
// below the count are ever read.
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded max-priority queue as a chain of cells
// Inserts keep the chain sorted largest first; removes take the head and
// shift the chain one cell toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,  // [31:0] value
    input  wire  [0:0]  s_tuser,  // [0] opcode
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,  // [31:0] removed_value, [35:32] entry_count
    output logic [1:0]  m_tuser   // [1:0] status
);

    count_t     fill_count_reg;
    count_t     fill_count_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;
    entry_t     removed_reg;
    entry_t     removed_next;
    count_t     out_count_reg;

    logic       s_fire;
    logic       is_full;
    logic       is_empty;
    logic       do_insert;
    logic       do_remove;
    entry_t     in_value;

    logic       keep_w  [QUEUE_DEPTH];
    entry_t     entry_w [QUEUE_DEPTH];
    logic [CNT_W+3:0] count_wide;

    // Handshake and operation decode.
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign in_value  = s_tdata;
    assign is_full   = (fill_count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty  = (fill_count_reg == '0);
    assign do_insert = s_fire && (s_tuser[0] == OP_INSERT) && !is_full;
    assign do_remove = s_fire && (s_tuser[0] == OP_REMOVE) && !is_empty;

    // The chain of cells; the head cell always sees a keeping neighbor.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        cell_ctrl_t ctrl;
        logic       lk;
        entry_t     le;
        entry_t     re;

        assign ctrl.insert   = do_insert;
        assign ctrl.remove   = do_remove;
        assign ctrl.occupied = (CNT_W'(i) < fill_count_reg);

        if (i == 0) begin : g_head
            assign lk = 1'b1;
            assign le = in_value;
        end else begin : g_body
            assign lk = keep_w[i-1];
            assign le = entry_w[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign re = entry_w[i];
        end else begin : g_mid
            assign re = entry_w[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .new_value   (in_value),
            .left_keep   (lk),
            .left_entry  (le),
            .right_entry (re),
            .keep        (keep_w[i]),
            .entry       (entry_w[i])
        );
    end

    // Fill count and result word.
    always_comb begin
        fill_count_next = fill_count_reg;
        m_tvalid_next   = m_tvalid_reg;
        status_next     = status_reg;
        removed_next    = removed_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (s_fire) begin
            m_tvalid_next = 1'b1;
            status_next   = STATUS_DONE;
            removed_next  = '0;
            if (s_tuser[0] == OP_INSERT) begin
                if (is_full) begin
                    status_next = STATUS_FULL;
                end else begin
                    fill_count_next = fill_count_reg + 1'b1;
                end
            end else begin
                if (is_empty) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    removed_next    = entry_w[0];
                    fill_count_next = fill_count_reg - 1'b1;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            fill_count_reg <= fill_count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Output payload registers.
    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        removed_reg   <= removed_next;
        out_count_reg <= s_fire ? fill_count_next : out_count_reg;
    end

    // The count field is four bits wide whatever the depth.
    assign count_wide = {4'b0000, out_count_reg};
    assign m_tvalid   = m_tvalid_reg;
    assign m_tuser    = status_reg;
    assign m_tdata    = {4'b0000, count_wide[3:0], removed_reg};

    // The count never passes the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count above queue depth");

    // A successful insert grows the count by one.
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |=> fill_count_reg == $past(fill_count_reg) + 1'b1)
        else $error("insert did not grow the count");

    // A remove on an empty queue reports empty and leaves the count at zero.
    a_empty_remove: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser[0] == OP_REMOVE && is_empty)
        |=> m_tvalid_reg && status_reg == STATUS_EMPTY && fill_count_reg == '0)
        else $error("empty remove handled wrongly");

    // The two front cells stay in non-increasing order.
    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_count_reg >= CNT_W'(2)) |-> !(entry_w[0] < entry_w[1]))
        else $error("head cells out of order");

endmodule

`default_nettype wire

FILE: sim/sorted_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb: self-checking bench for the sorted priority queue
// Streams insert and remove words into the queue, keeps a shadow copy of the
// sorted contents to predict each result word, and compares every field of
// each result against the oldest prediction under several idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_tb;
    import spq_pkg::*;

    // One queue operation as carried on the input stream.
    typedef struct {
        logic   opcode;
        entry_t value;
    } queue_op_t;

    // One predicted result word.
    typedef struct {
        logic [1:0] status;
        entry_t     removed;
        logic [3:0] count;
    } queue_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] value
    logic [0:0]  s_tuser = '0;   // [0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // [31:0] removed_value, [35:32] entry_count
    logic [1:0]  m_tuser;        // [1:0] status

    queue_op_t     op_backlog[$];
    queue_result_t expected_results[$];
    entry_t        shadow_entries[$];   // largest value at index 0
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    logic          recv_hold = 1'b0;
    int            mismatches = 0;

    sorted_priority_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Apply one operation to the shadow queue and return the result it causes.
    function automatic queue_result_t apply_queue_op(queue_op_t op);
        queue_result_t res;
        int            pos;
        res.status  = STATUS_DONE;
        res.removed = '0;
        if (op.opcode == OP_INSERT) begin
            if (shadow_entries.size() >= QUEUE_DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                // New value goes behind every stored value that is not smaller.
                pos = shadow_entries.size();
                while (pos > 0 && shadow_entries[pos-1] < op.value) pos--;
                shadow_entries.insert(pos, op.value);
            end
        end else if (shadow_entries.size() == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.removed = shadow_entries.pop_front();
        end
        res.count = 4'(shadow_entries.size());
        return res;
    endfunction

    // Random operation; values favor extremes and a narrow band that makes ties.
    function automatic queue_op_t random_queue_op(int insert_pct);
        queue_op_t op;
        op.opcode = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        case ($urandom_range(9))
            0: op.value = 32'h7fff_ffff;
            1: op.value = 32'h8000_0000;
            2, 3, 4: op.value = entry_t'($urandom_range(6)) - 3;
            default: op.value = $urandom;
        endcase
        return op;
    endfunction

    task automatic push_op(logic opcode, entry_t value);
        op_backlog.push_back('{opcode, value});
    endtask

    // Hold the sender back until every queued word has gone in and come out.
    task automatic wait_for_drain();
        while (op_backlog.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic report_mismatch(string field, logic [39:0] want, logic [39:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        mismatches++;
    endtask

    // Driver: offers the next pending word, predicting each one as it is taken.
    always @(posedge aclk) begin
        queue_op_t next_op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) expected_results.push_back(apply_queue_op('{s_tuser[0], s_tdata}));
            if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_op = op_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_op.opcode;
                s_tdata  <= next_op.value;
            end else begin
                // Idle cycle: data lines carry noise.
                s_tvalid <= 1'b0;
                s_tuser  <= 1'($urandom);
                s_tdata  <= $urandom;
            end
        end
    end

    // Monitor: checks each accepted result word against the oldest prediction.
    always @(posedge aclk) begin
        queue_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %0h/%0h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", 40'(want.status), 40'(m_tuser));
                    if (m_tdata[31:0] !== want.removed)
                        report_mismatch("removed_value", 40'(want.removed), 40'(m_tdata[31:0]));
                    if (m_tdata[39:32] !== {4'd0, want.count})
                        report_mismatch("entry_count", 40'(want.count), 40'(m_tdata[39:32]));
                end
            end
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus and phase control.
    initial begin
        int idle_pct[4];
        int stall_pct[4];
        int insert_pct;

        idle_pct  = '{0, 86, 0, 14};
        stall_pct = '{0, 0, 86, 14};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Remove on empty, fill with extremes and near-zero values, insert on full,
        // then drain past empty; removes carry noise in the value field.
        push_op(OP_REMOVE, 32'h1234_5678);
        push_op(OP_INSERT, 32'h7fff_ffff);
        push_op(OP_INSERT, 32'h8000_0000);
        push_op(OP_INSERT, 32'h0000_0000);
        push_op(OP_INSERT, 32'hffff_ffff);
        push_op(OP_INSERT, 32'h0000_0001);
        push_op(OP_INSERT, 32'h0000_0000);
        push_op(OP_INSERT, 32'h7fff_ffff);
        push_op(OP_INSERT, 32'h8000_0000);
        push_op(OP_INSERT, 32'h5555_aaaa);
        repeat (9) push_op(OP_REMOVE, 32'hffff_ffff);
        wait_for_drain();

        // Random bursts that lean toward filling or emptying the queue.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            for (int burst = 0; burst < 15; burst++) begin
                insert_pct = $urandom_range(1) ? 70 : 30;
                repeat (30) op_backlog.push_back(random_queue_op(insert_pct));
            end
            wait_for_drain();
        end

        // Receiver holds off for a long stretch while the sender keeps offering.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (200) @(negedge aclk);
                recv_hold = 1'b0;
            end
        join_none
        repeat (40) op_backlog.push_back(random_queue_op(60));
        wait_for_drain();

        repeat (5) @(negedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
